@@ rtl/wbhs_pkg.sv @@
// shared constants for the weighted bucket histogram statistics block
package wbhs_pkg;

    localparam int NUM_BUCKETS_DEF = 256;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int BW_W      = 16;
    localparam int WEIGHT_W  = 16;
    localparam int CNT_W     = 40;
    localparam int WSUM_W    = 48;
    localparam int AVG_W     = 25;
    localparam int AVG_FRAC  = 8;
    localparam int MID_OUT_W = 17;
    localparam int RUN_W     = CNT_W + 1;

    localparam int OUT_FIELDS_W = WSUM_W + CNT_W + AVG_W + 3 * MID_OUT_W + CNT_W + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [BW_W-1:0] BW_RESET = BW_W'(1);

endpackage

@@ rtl/wbhs_ram.sv @@
// generic single write, single read ram with registered read data
module wbhs_ram #(
    parameter int WIDTH = 41,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/weighted_bucket_histogram_stats.sv @@
// weighted bucket histogram with end-of-set statistics report
// Each sample item runs a bit-serial divide of the sample by the bucket width (one
// quotient bit per cycle), then a bucket read-modify-write and a middle*weight multiply.
// An item marked last then starts the report: a walk over the bucket ram (which also
// clears it), a bit-serial divide for the average (skipped when the total weight is
// zero) and the three bucket middles in turn, then the result goes to the output
// register. After reset a clearing pass over the bucket ram runs before the first
// item is taken; configuration writes are taken at any time. The next item may be
// taken while a result waits on the output.
module weighted_bucket_histogram_stats #(
    parameter int NUM_BUCKETS = wbhs_pkg::NUM_BUCKETS_DEF,
    parameter int SAMPLE_BITS = wbhs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            cfg_valid,
    output logic                                            cfg_ready,
    input  logic [wbhs_pkg::BW_W-1:0]                       cfg_data,
    input  logic                                            s_axis_tvalid,
    output logic                                            s_axis_tready,
    // sample_value, weight
    input  logic [((SAMPLE_BITS+wbhs_pkg::WEIGHT_W+7)/8)*8-1:0] s_axis_tdata,
    input  logic                                            s_axis_tlast,
    output logic                                            m_axis_tvalid,
    input  logic                                            m_axis_tready,
    // weighted_total, total_weight, average_fixed, median_middle, min_middle,
    // max_middle, peak_height, clipped
    output logic [wbhs_pkg::OUT_TDATA_W-1:0]                m_axis_tdata,
    // empty_res
    output logic                                            m_axis_tuser
);

    localparam int IDXW   = $clog2(NUM_BUCKETS);
    localparam int CTRW   = $clog2(NUM_BUCKETS + 1);
    localparam int MID_W  = IDXW + wbhs_pkg::BW_W + 1;
    localparam int PROD_W = MID_W + wbhs_pkg::WEIGHT_W;
    localparam int SCNT_W = $clog2(SAMPLE_BITS + 1);
    localparam int ENT_W  = wbhs_pkg::CNT_W + 1;
    localparam int ADIV_N = wbhs_pkg::WSUM_W + wbhs_pkg::AVG_FRAC;
    localparam int ACNT_W = $clog2(ADIV_N);
    localparam int BW_W   = wbhs_pkg::BW_W;
    localparam int WT_W   = wbhs_pkg::WEIGHT_W;
    localparam int CNT_W  = wbhs_pkg::CNT_W;
    localparam int WSUM_W = wbhs_pkg::WSUM_W;
    localparam int AVG_W  = wbhs_pkg::AVG_W;
    localparam int MO_W   = wbhs_pkg::MID_OUT_W;
    localparam int RUN_W  = wbhs_pkg::RUN_W;

    localparam logic [wbhs_pkg::AVG_FRAC-1:0] AVG_FRAC_ZERO = '0;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_DIV, S_MID, S_UPD, S_ACC, S_WALK, S_AVG, S_MIDS, S_OUT
    } state_t;

    state_t                state_reg;
    logic [BW_W-1:0]       bw_reg;
    logic [SAMPLE_BITS-1:0] dvd_reg;
    logic [BW_W-1:0]       rem_reg;
    logic [SCNT_W-1:0]     scnt_reg;
    logic [WT_W-1:0]       weight_reg;
    logic                  last_reg;
    logic [IDXW-1:0]       idx_reg;
    logic [MID_W-1:0]      mid_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [WSUM_W-1:0]     wsum_reg;
    logic [CNT_W-1:0]      wtsum_reg;
    logic [IDXW-1:0]       low_reg;
    logic [IDXW-1:0]       high_reg;
    logic                  clip_reg;
    logic [CTRW-1:0]       wcnt_reg;
    logic                  pv_reg;
    logic [IDXW-1:0]       paddr_reg;
    logic                  any_reg;
    logic                  found_reg;
    logic [RUN_W-1:0]      run_reg;
    logic [CNT_W-1:0]      peak_reg;
    logic [IDXW-1:0]       med_idx_reg;
    logic [ADIV_N-1:0]     advd_reg;
    logic [CNT_W-1:0]      arem_reg;
    logic [ACNT_W-1:0]     acnt_reg;
    logic [AVG_W-1:0]      avg_reg;
    logic [1:0]            mstep_reg;
    logic [MO_W-1:0]       med_mid_reg;
    logic [MO_W-1:0]       low_mid_reg;
    logic [MO_W-1:0]       high_mid_reg;
    logic                  out_valid_reg;
    logic [wbhs_pkg::OUT_TDATA_W-1:0] out_data_reg;
    logic                  out_user_reg;

    logic [BW_W-1:0]       eff_w;
    logic [BW_W:0]         rem_sh;
    logic                  s_ge;
    logic [BW_W:0]         rem_sub;
    logic [31:0]           q32;
    logic [CNT_W:0]        arem_sh;
    logic                  a_ge;
    logic [CNT_W:0]        arem_sub;
    logic [IDXW-1:0]       mul_idx;
    logic [MID_W-1:0]      mid_val;
    logic [ENT_W-1:0]      rdata;
    logic [CNT_W-1:0]      rcount;
    logic [CNT_W:0]        cnt_sum;
    logic [CNT_W-1:0]      cnt_new;
    logic [CNT_W:0]        wt_sum;
    logic [WSUM_W:0]       ws_sum;
    logic [RUN_W:0]        run_sum;
    logic [RUN_W-1:0]      run_new;
    logic                  ram_we;
    logic [IDXW-1:0]       ram_waddr;
    logic [ENT_W-1:0]      ram_wdata;
    logic                  ram_re;
    logic [IDXW-1:0]       ram_raddr;
    logic                  walk_more;
    logic                  out_free;
    logic                  out_load;
    logic [wbhs_pkg::OUT_FIELDS_W-1:0] out_fields;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    assign eff_w    = (bw_reg == '0) ? BW_W'(1) : bw_reg;
    assign rem_sh   = {rem_reg, dvd_reg[SAMPLE_BITS-1]};
    assign s_ge     = rem_sh >= {1'b0, eff_w};
    assign rem_sub  = s_ge ? (rem_sh - {1'b0, eff_w}) : rem_sh;
    assign q32      = 32'(dvd_reg);
    assign arem_sh  = {arem_reg, advd_reg[ADIV_N-1]};
    assign a_ge     = arem_sh >= {1'b0, wtsum_reg};
    assign arem_sub = a_ge ? (arem_sh - {1'b0, wtsum_reg}) : arem_sh;

    always_comb
    begin
        unique case (mstep_reg)
            2'd0:    mul_idx = found_reg ? med_idx_reg : high_reg;
            2'd1:    mul_idx = low_reg;
            default: mul_idx = high_reg;
        endcase
        if (state_reg != S_MIDS)
        begin
            mul_idx = idx_reg;
        end
    end

    assign mid_val = MID_W'(mul_idx) * MID_W'(eff_w) + MID_W'(eff_w >> 1);

    assign rcount  = rdata[CNT_W-1:0];
    assign cnt_sum = {1'b0, rcount} + (CNT_W+1)'(weight_reg);
    assign cnt_new = cnt_sum[CNT_W] ? '1 : cnt_sum[CNT_W-1:0];
    assign wt_sum  = {1'b0, wtsum_reg} + (CNT_W+1)'(weight_reg);
    assign ws_sum  = {1'b0, wsum_reg} + (WSUM_W+1)'(prod_reg);
    assign run_sum = {1'b0, run_reg} + (RUN_W+1)'(rcount);
    assign run_new = run_sum[RUN_W] ? '1 : run_sum[RUN_W-1:0];

    assign walk_more = (wcnt_reg != CTRW'(NUM_BUCKETS));
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign out_load  = (state_reg == S_OUT) && out_free;

    assign out_fields = {clip_reg, peak_reg, high_mid_reg, low_mid_reg, med_mid_reg,
                         avg_reg, wtsum_reg, wsum_reg};

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = idx_reg;
        unique case (state_reg)
            S_CLR:
            begin
                ram_we    = 1'b1;
                ram_waddr = wcnt_reg[IDXW-1:0];
            end
            S_MID:
            begin
                ram_re = 1'b1;
            end
            S_UPD:
            begin
                ram_we    = 1'b1;
                ram_wdata = {1'b1, cnt_new};
            end
            S_WALK:
            begin
                ram_re    = walk_more;
                ram_raddr = wcnt_reg[IDXW-1:0];
                ram_we    = pv_reg;
                ram_waddr = paddr_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    wbhs_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_BUCKETS)
    ) u_bucket_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            bw_reg        <= wbhs_pkg::BW_RESET;
            dvd_reg       <= '0;
            rem_reg       <= '0;
            scnt_reg      <= '0;
            weight_reg    <= '0;
            last_reg      <= 1'b0;
            idx_reg       <= '0;
            mid_reg       <= '0;
            prod_reg      <= '0;
            wsum_reg      <= '0;
            wtsum_reg     <= '0;
            low_reg       <= '1;
            high_reg      <= '0;
            clip_reg      <= 1'b0;
            wcnt_reg      <= '0;
            pv_reg        <= 1'b0;
            paddr_reg     <= '0;
            any_reg       <= 1'b0;
            found_reg     <= 1'b0;
            run_reg       <= '0;
            peak_reg      <= '0;
            med_idx_reg   <= '0;
            advd_reg      <= '0;
            arem_reg      <= '0;
            acnt_reg      <= '0;
            avg_reg       <= '0;
            mstep_reg     <= '0;
            med_mid_reg   <= '0;
            low_mid_reg   <= '0;
            high_mid_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_user_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                bw_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLR:
                begin
                    if (wcnt_reg == CTRW'(NUM_BUCKETS - 1))
                    begin
                        wcnt_reg  <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        wcnt_reg <= wcnt_reg + CTRW'(1);
                    end
                end
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        dvd_reg    <= s_axis_tdata[SAMPLE_BITS-1:0];
                        weight_reg <= s_axis_tdata[SAMPLE_BITS +: WT_W];
                        last_reg   <= s_axis_tlast;
                        rem_reg    <= '0;
                        scnt_reg   <= '0;
                        state_reg  <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (scnt_reg == SCNT_W'(SAMPLE_BITS))
                    begin
                        if (q32 >= 32'(NUM_BUCKETS))
                        begin
                            idx_reg  <= IDXW'(NUM_BUCKETS - 1);
                            clip_reg <= 1'b1;
                        end
                        else
                        begin
                            idx_reg <= q32[IDXW-1:0];
                        end
                        state_reg <= S_MID;
                    end
                    else
                    begin
                        dvd_reg  <= {dvd_reg[SAMPLE_BITS-2:0], s_ge};
                        rem_reg  <= rem_sub[BW_W-1:0];
                        scnt_reg <= scnt_reg + SCNT_W'(1);
                    end
                end
                S_MID:
                begin
                    mid_reg   <= mid_val;
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    prod_reg  <= PROD_W'(mid_reg) * PROD_W'(weight_reg);
                    wtsum_reg <= wt_sum[CNT_W] ? '1 : wt_sum[CNT_W-1:0];
                    if (idx_reg < low_reg)
                    begin
                        low_reg <= idx_reg;
                    end
                    if (idx_reg > high_reg)
                    begin
                        high_reg <= idx_reg;
                    end
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    wsum_reg <= ws_sum[WSUM_W] ? '1 : ws_sum[WSUM_W-1:0];
                    wcnt_reg <= '0;
                    pv_reg   <= 1'b0;
                    state_reg <= last_reg ? S_WALK : S_IDLE;
                end
                S_WALK:
                begin
                    pv_reg    <= walk_more;
                    paddr_reg <= wcnt_reg[IDXW-1:0];
                    if (walk_more)
                    begin
                        wcnt_reg <= wcnt_reg + CTRW'(1);
                    end
                    if (pv_reg && rdata[CNT_W])
                    begin
                        any_reg <= 1'b1;
                        run_reg <= run_new;
                        if (rcount > peak_reg)
                        begin
                            peak_reg <= rcount;
                        end
                        if (!found_reg && ({run_new, 1'b0} >= (RUN_W+1)'(wtsum_reg)))
                        begin
                            found_reg   <= 1'b1;
                            med_idx_reg <= paddr_reg;
                        end
                    end
                    if (!walk_more && !pv_reg)
                    begin
                        advd_reg  <= {wsum_reg, AVG_FRAC_ZERO};
                        arem_reg  <= '0;
                        acnt_reg  <= '0;
                        avg_reg   <= '0;
                        mstep_reg <= '0;
                        state_reg <= (wtsum_reg == '0) ? S_MIDS : S_AVG;
                    end
                end
                S_AVG:
                begin
                    advd_reg <= {advd_reg[ADIV_N-2:0], a_ge};
                    arem_reg <= arem_sub[CNT_W-1:0];
                    acnt_reg <= acnt_reg + ACNT_W'(1);
                    if (acnt_reg == ACNT_W'(ADIV_N - 1))
                    begin
                        if (advd_reg[ADIV_N-2:AVG_W-1] != '0)
                        begin
                            avg_reg <= '1;
                        end
                        else
                        begin
                            avg_reg <= {advd_reg[AVG_W-2:0], a_ge};
                        end
                        state_reg <= S_MIDS;
                    end
                end
                S_MIDS:
                begin
                    unique case (mstep_reg)
                        2'd0:    med_mid_reg  <= mid_val[MO_W-1:0];
                        2'd1:    low_mid_reg  <= mid_val[MO_W-1:0];
                        default: high_mid_reg <= mid_val[MO_W-1:0];
                    endcase
                    mstep_reg <= mstep_reg + 2'd1;
                    if (mstep_reg == 2'd2)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_user_reg  <= !any_reg;
                        out_data_reg  <= any_reg ? wbhs_pkg::OUT_TDATA_W'(out_fields) : '0;
                        wsum_reg      <= '0;
                        wtsum_reg     <= '0;
                        low_reg       <= '1;
                        high_reg      <= '0;
                        clip_reg      <= 1'b0;
                        any_reg       <= 1'b0;
                        found_reg     <= 1'b0;
                        run_reg       <= '0;
                        peak_reg      <= '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/wbhs_checker.sv @@
// port-level checks for the histogram statistics block and its bind
module wbhs_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [wbhs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             m_axis_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output item changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while one is at work");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("empty report carries nonzero statistics");

endmodule

bind weighted_bucket_histogram_stats wbhs_checker u_wbhs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ tb/sv/weighted_bucket_histogram_stats_tb.sv @@
// testbench for the weighted bucket histogram statistics block with self-checking predictor
`timescale 1ns / 1ps

module weighted_bucket_histogram_stats_tb;

    localparam int NB = wbhs_pkg::NUM_BUCKETS_DEF;
    localparam int WDOG_LIMIT = 40000;
    localparam int SETTLE = 400;

    typedef struct packed {
        logic [15:0] sample;
        logic [15:0] weight;
        logic        last;
    } sample_item_t;

    typedef struct packed {
        logic        empty;
        logic [47:0] wtotal;
        logic [39:0] tweight;
        logic [24:0] avg;
        logic [16:0] median;
        logic [16:0] min_mid;
        logic [16:0] max_mid;
        logic [39:0] peak;
        logic        clip;
    } hist_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [wbhs_pkg::BW_W-1:0] cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic s_axis_tlast = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [wbhs_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic m_axis_tuser;

    sample_item_t pending_items[$];
    hist_report_t expected_reports[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int holdoff_req = 0;
    int holdoff_seen = 0;
    int holdoff_left = 0;
    int mismatches = 0;
    int idle_cycles = 0;

    // predictor state
    logic [15:0]    model_width = wbhs_pkg::BW_RESET;
    longint unsigned bucket_cnt[NB];
    bit             bucket_hit[NB];
    longint unsigned sum_weighted;
    longint unsigned sum_weight;
    int             low_idx;
    int             high_idx;
    bit             clip_flag;

    weighted_bucket_histogram_stats i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint unsigned eff_width();
        return (model_width == 0) ? 1 : longint'(model_width);
    endfunction

    function automatic longint unsigned bucket_middle(int idx);
        longint unsigned w;
        w = eff_width();
        return longint'(idx) * w + (w >> 1);
    endfunction

    function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b,
                                                int bits);
        longint unsigned cap;
        cap = (64'd1 << bits) - 1;
        return (a + b > cap) ? cap : a + b;
    endfunction

    function automatic void clear_histogram();
        for (int i = 0; i < NB; i++)
        begin
            bucket_cnt[i] = 0;
            bucket_hit[i] = 0;
        end
        sum_weighted = 0;
        sum_weight = 0;
        low_idx = NB - 1;
        high_idx = 0;
        clip_flag = 0;
    endfunction

    function automatic void bin_sample(sample_item_t it);
        longint unsigned idx;
        longint unsigned run;
        longint unsigned med;
        longint unsigned pk;
        longint unsigned av;
        bit any;
        bit found;
        hist_report_t r;
        idx = longint'(it.sample) / eff_width();
        if (idx >= NB)
        begin
            idx = NB - 1;
            clip_flag = 1;
        end
        bucket_cnt[idx] = sat_sum(bucket_cnt[idx], it.weight, wbhs_pkg::CNT_W);
        bucket_hit[idx] = 1;
        sum_weight = sat_sum(sum_weight, it.weight, wbhs_pkg::CNT_W);
        sum_weighted = sat_sum(sum_weighted, bucket_middle(int'(idx)) * it.weight,
                               wbhs_pkg::WSUM_W);
        if (int'(idx) < low_idx)
            low_idx = int'(idx);
        if (int'(idx) > high_idx)
            high_idx = int'(idx);
        if (!it.last)
            return;
        any = 0;
        found = 0;
        run = 0;
        med = 0;
        pk = 0;
        for (int i = 0; i < NB; i++)
        begin
            if (bucket_hit[i])
            begin
                any = 1;
                if (bucket_cnt[i] > pk)
                    pk = bucket_cnt[i];
                run += bucket_cnt[i];
                if (!found && 2 * run >= sum_weight)
                begin
                    found = 1;
                    med = bucket_middle(i);
                end
            end
        end
        if (!found)
            med = bucket_middle(high_idx);
        r = '0;
        if (!any)
            r.empty = 1;
        else
        begin
            av = 0;
            if (sum_weight != 0)
            begin
                av = (sum_weighted << 8) / sum_weight;
                if (av > (64'd1 << wbhs_pkg::AVG_W) - 1)
                    av = (64'd1 << wbhs_pkg::AVG_W) - 1;
            end
            r.wtotal = sum_weighted[47:0];
            r.tweight = sum_weight[39:0];
            r.avg = av[24:0];
            r.median = med[16:0];
            r.min_mid = 17'(bucket_middle(low_idx));
            r.max_mid = 17'(bucket_middle(high_idx));
            r.peak = pk[39:0];
            r.clip = clip_flag;
        end
        expected_reports.push_back(r);
        clear_histogram();
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        sample_item_t acc;
        sample_item_t nxt;
        logic busy;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            busy = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                acc.sample = s_axis_tdata[15:0];
                acc.weight = s_axis_tdata[31:16];
                acc.last = s_axis_tlast;
                bin_sample(acc);
                busy = 1'b0;
            end
            if (!busy)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_items.pop_front();
                    s_axis_tdata <= {nxt.weight, nxt.sample};
                    s_axis_tlast <= nxt.last;
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (holdoff_req != holdoff_seen)
        begin
            holdoff_seen <= holdoff_req;
            holdoff_left <= 3000;
            m_axis_tready <= 1'b0;
        end
        else if (holdoff_left > 0)
        begin
            holdoff_left <= holdoff_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        hist_report_t e;
        hist_report_t a;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            a.empty = m_axis_tuser;
            a.wtotal = m_axis_tdata[47:0];
            a.tweight = m_axis_tdata[87:48];
            a.avg = m_axis_tdata[112:88];
            a.median = m_axis_tdata[129:113];
            a.min_mid = m_axis_tdata[146:130];
            a.max_mid = m_axis_tdata[163:147];
            a.peak = m_axis_tdata[203:164];
            a.clip = m_axis_tdata[204];
            if (expected_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected report: %p", a);
            end
            else
            begin
                e = expected_reports.pop_front();
                if (a !== e)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("report mismatch\n  expected %p\n  actual   %p", e, a);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic push_item(int sample, int weight, bit last);
        sample_item_t it;
        it.sample = sample[15:0];
        it.weight = weight[15:0];
        it.last = last;
        pending_items.push_back(it);
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || s_axis_tvalid || expected_reports.size() > 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_width(logic [15:0] w);
        cfg_data <= w;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        model_width = w;
    endtask

    task automatic push_random_sets(int count);
        longint unsigned span;
        int len;
        int smp;
        int wgt;
        int r;
        span = eff_width() * 260;
        if (span > 65535)
            span = 65535;
        for (int n = 0; n < count; n += len)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
            for (int k = 0; k < len; k++)
            begin
                r = $urandom_range(99);
                smp = (r < 15) ? $urandom_range(65535) : $urandom_range(int'(span));
                r = $urandom_range(99);
                wgt = (r < 8) ? 0 : (r < 16) ? 65535 : (r < 50) ? $urandom_range(15, 1)
                    : $urandom_range(65535);
                push_item(smp, wgt, k == len - 1);
            end
        end
    endtask

    initial
    begin
        clear_histogram();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // zero weight alone, clipping, zero total across two buckets
        push_item(0, 0, 1);
        push_item(65535, 65535, 0);
        push_item(255, 1, 0);
        push_item(0, 65535, 1);
        push_item(7, 0, 0);
        push_item(9, 0, 1);
        push_item(3, 5, 1);
        push_item(100, 2, 0);
        push_item(100, 3, 0);
        push_item(200, 4, 1);
        wait_drained();
        write_width(16'd0);
        push_item(5, 2, 0);
        push_item(300, 1, 1);
        wait_drained();
        write_width(16'hFFFF);
        push_item(65535, 65535, 0);
        push_item(0, 1, 1);
        push_item(32767, 65535, 1);
        // set left open across a width change
        push_item(65534, 7, 0);
        wait_drained();
        write_width(16'd3);
        push_item(10, 9, 1);

        for (int ph = 0; ph < 8; ph++)
        begin
            wait_drained();
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            case (ph)
                0: write_width(16'd256);
                1: write_width(16'd1);
                2: write_width(16'hFFFF);
                3: write_width(16'd0);
                default: write_width(16'($urandom_range(400, 1) << $urandom_range(7)));
            endcase
            if (ph == 4)
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
                holdoff_req = holdoff_req + 1;
                for (int k = 0; k < 40; k++)
                    push_item($urandom_range(65535), $urandom_range(65535), 1);
            end
            push_random_sets(180);
        end
        wait_drained();

        if (mismatches == 0 && expected_reports.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
